>>> design/itoar_pkg.sv
`default_nettype none

package itoar_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int DIGIT_BUFFER_DEPTH = 17;
    localparam int PTR_W = $clog2(DIGIT_BUFFER_DEPTH + 1);
    localparam int IDX_W = $clog2(DIGIT_BUFFER_DEPTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int PC_W = 3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_START,
        C_DIV_MORE,
        C_QUOT_NZ,
        C_MORE_CHARS
    } t_cond;

    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [PC_W-1:0] STEP_DIV = 3'd1;
    localparam logic [PC_W-1:0] STEP_PUSH = 3'd2;
    localparam logic [PC_W-1:0] STEP_SIGN = 3'd3;
    localparam logic [PC_W-1:0] STEP_EMIT = 3'd4;
    localparam logic [PC_W-1:0] STEP_DONE = 3'd5;

    typedef struct packed {
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            op_load;
        logic            op_div;
        logic            op_push_digit;
        logic            op_push_sign;
        logic            op_emit;
    } t_ctrl;

    typedef struct packed {
        logic div_more;
        logic quot_nz;
        logic more_chars;
    } t_stat;

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{cond: C_ALWAYS, target: STEP_IDLE, default: 1'b0};
        unique case (pc)
            STEP_IDLE: begin
                w.cond = C_NOT_START;
                w.target = STEP_IDLE;
                w.op_load = 1'b1;
            end
            STEP_DIV: begin
                w.cond = C_DIV_MORE;
                w.target = STEP_DIV;
                w.op_div = 1'b1;
            end
            STEP_PUSH: begin
                w.cond = C_QUOT_NZ;
                w.target = STEP_DIV;
                w.op_push_digit = 1'b1;
            end
            STEP_SIGN: begin
                w.cond = C_NEXT;
                w.op_push_sign = 1'b1;
            end
            STEP_EMIT: begin
                w.cond = C_MORE_CHARS;
                w.target = STEP_EMIT;
                w.op_emit = 1'b1;
            end
            STEP_DONE: begin
                w.cond = C_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
                w.cond = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] c;
        if (digit < 4'd10) begin
            c = CHAR_ZERO + {4'd0, digit};
        end else begin
            c = CHAR_A + {4'd0, digit} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/itoar_seq.sv
`default_nettype none

module itoar_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  itoar_pkg::t_stat             i_stat,
    output itoar_pkg::t_ctrl             o_ctrl,
    output logic                         o_busy
);

    logic [itoar_pkg::PC_W-1:0] r_pc;
    logic [itoar_pkg::PC_W-1:0] n_pc;
    itoar_pkg::t_ctrl           ctrl;
    logic                       take;

    always_comb begin
        ctrl = itoar_pkg::ucode(r_pc);
        unique case (ctrl.cond)
            itoar_pkg::C_NEXT:       take = 1'b0;
            itoar_pkg::C_ALWAYS:     take = 1'b1;
            itoar_pkg::C_NOT_START:  take = !i_start;
            itoar_pkg::C_DIV_MORE:   take = i_stat.div_more;
            itoar_pkg::C_QUOT_NZ:    take = i_stat.quot_nz;
            itoar_pkg::C_MORE_CHARS: take = i_stat.more_chars;
            default:                 take = 1'b1;
        endcase
        n_pc = take ? ctrl.target : r_pc + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= itoar_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;
    assign o_busy = (r_pc != itoar_pkg::STEP_IDLE);

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("transfer accepted but sequencer stayed idle");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= itoar_pkg::STEP_DONE)
        else $error("step counter left the program");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == itoar_pkg::STEP_DONE |=> !o_busy)
        else $error("sequencer did not return to idle");

endmodule

`default_nettype wire

>>> design/itoar_dp.sv
`default_nettype none

module itoar_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire                                   i_cmd,
    input  wire  [itoar_pkg::VALUE_WIDTH-1:0]     i_value,
    input  wire  [4:0]                            i_base,
    input  itoar_pkg::t_ctrl                      i_ctrl,
    output itoar_pkg::t_stat                      o_stat,
    output logic [7:0]                            o_ascii_char,
    output logic                                  o_last,
    output logic                                  o_strobe
);

    logic [itoar_pkg::VALUE_WIDTH-1:0] r_quot;
    logic [3:0]                        r_rem;
    logic [4:0]                        r_base;
    logic                              r_neg;
    logic [itoar_pkg::CNT_W-1:0]       r_cnt;
    logic [itoar_pkg::PTR_W-1:0]       r_ptr;
    logic [7:0]                        r_stack [itoar_pkg::DIGIT_BUFFER_DEPTH];
    logic [7:0]                        r_char;
    logic                              r_last;
    logic                              r_strobe;

    logic [4:0]                        trial;
    logic                              fits;
    logic [4:0]                        diff;
    logic [4:0]                        base_clamped;
    logic                              push;
    logic [7:0]                        push_char;
    logic [itoar_pkg::IDX_W-1:0]       wr_idx;
    logic [itoar_pkg::IDX_W-1:0]       rd_idx;
    logic [itoar_pkg::PTR_W-1:0]       ptr_dec;

    always_comb begin
        trial = {r_rem, r_quot[itoar_pkg::VALUE_WIDTH-1]};
        fits = (trial >= r_base);
        diff = trial - r_base;
        if (i_base < itoar_pkg::BASE_MIN) begin
            base_clamped = itoar_pkg::BASE_MIN;
        end else if (i_base > itoar_pkg::BASE_MAX) begin
            base_clamped = itoar_pkg::BASE_MAX;
        end else begin
            base_clamped = i_base;
        end
        push = i_ctrl.op_push_digit || (i_ctrl.op_push_sign && r_neg);
        push_char = i_ctrl.op_push_digit ? itoar_pkg::glyph(r_rem) : itoar_pkg::CHAR_MINUS;
        ptr_dec = r_ptr - 1'b1;
        wr_idx = r_ptr[itoar_pkg::IDX_W-1:0];
        rd_idx = ptr_dec[itoar_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op_load && i_start) begin
            r_neg <= i_cmd && i_value[itoar_pkg::VALUE_WIDTH-1];
            r_quot <= (i_cmd && i_value[itoar_pkg::VALUE_WIDTH-1])
                    ? ('0 - i_value) : i_value;
            r_base <= base_clamped;
            r_rem <= '0;
            r_cnt <= itoar_pkg::CNT_W'(itoar_pkg::VALUE_WIDTH - 1);
        end
        if (i_ctrl.op_div) begin
            r_quot <= {r_quot[itoar_pkg::VALUE_WIDTH-2:0], fits};
            r_rem <= fits ? diff[3:0] : trial[3:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_ctrl.op_push_digit) begin
            r_rem <= '0;
            r_cnt <= itoar_pkg::CNT_W'(itoar_pkg::VALUE_WIDTH - 1);
        end
        if (push) begin
            r_stack[wr_idx] <= push_char;
        end
        if (i_ctrl.op_emit) begin
            r_char <= r_stack[rd_idx];
            r_last <= (r_ptr == itoar_pkg::PTR_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.op_emit;
            if (i_ctrl.op_load && i_start) begin
                r_ptr <= '0;
            end else if (push) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (i_ctrl.op_emit) begin
                r_ptr <= ptr_dec;
            end
        end
    end

    assign o_stat.div_more = (r_cnt != '0);
    assign o_stat.quot_nz = (r_quot != '0);
    assign o_stat.more_chars = (r_ptr != itoar_pkg::PTR_W'(1));
    assign o_ascii_char = r_char;
    assign o_last = r_last;
    assign o_strobe = r_strobe;

    a_ptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= itoar_pkg::PTR_W'(itoar_pkg::DIGIT_BUFFER_DEPTH))
        else $error("digit stack overflow");

    a_emit_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op_emit |-> r_ptr != '0)
        else $error("emit from empty digit stack");

    a_last_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("transfer after last character");

endmodule

`default_nettype wire

>>> design/integer_to_ascii_radix.sv
// from start to the first character, each of the n digits takes 16 restoring division steps
// plus one digit push, then comes the sign step
// throughput: one character per cycle once emitting, then the sequencer returns idle;
// the text holds n characters, or n + 1 with a sign
// the receiver cannot stall: each character is valid for one cycle under o_strobe
// reset: synchronous active low, returns the sequencer to idle and empties the digit stack
`default_nettype none

module integer_to_ascii_radix (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               i_cmd,
    input  wire  [itoar_pkg::VALUE_WIDTH-1:0] i_value,
    input  wire  [4:0]                        i_base,
    output logic [7:0]                        o_ascii_char,
    output logic                              o_last,
    output logic                              o_strobe
);

    itoar_pkg::t_ctrl ctrl;
    itoar_pkg::t_stat stat;

    itoar_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    itoar_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_base       (i_base),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_strobe     (o_strobe)
    );

endmodule

`default_nettype wire

>>> bench/tb_integer_to_ascii_radix.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_radix;

    localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [15:0] i_value;
    logic [4:0]  i_base;
    logic [7:0]  o_ascii_char;
    logic        o_last;
    logic        o_strobe;

    text_char_t pending_chars[$];
    int         error_count = 0;
    int         stall_cycles = 0;
    int         sender_idle_pct = 0;

    integer_to_ascii_radix dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_base       (i_base),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_strobe     (o_strobe)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected text of one number, most significant character first
    function automatic void predict_text(input logic cmd, input logic [15:0] value,
                                         input logic [4:0] base);
        int unsigned radix;
        int unsigned magnitude;
        logic        negative;
        logic [7:0]  reversed[17];
        int          n;
        text_char_t  c;
        radix = {27'd0, base};
        if (radix < 2) radix = 2;
        if (radix > 16) radix = 16;
        negative = cmd && value[15];
        magnitude = negative ? ((32'h10000 - {16'd0, value}) & 32'hffff) : {16'd0, value};
        n = 0;
        do begin
            reversed[n] = DIGIT_GLYPHS[(15 - (magnitude % radix)) * 8 +: 8];
            n++;
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (negative) begin
            reversed[n] = itoar_pkg::CHAR_MINUS;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.code = reversed[k];
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic int draw_gap();
        int g;
        g = 0;
        if ($urandom_range(99) < sender_idle_pct) begin
            if ($urandom_range(3) == 0) g = $urandom_range(13, 320);
            else g = $urandom_range(1, 12);
        end
        return g;
    endfunction

    task automatic send_number(input logic cmd, input logic [15:0] value,
                               input logic [4:0] base);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_value <= value;
        i_base <= base;
        // wait for a cycle with busy low, the next rising edge takes the transfer
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        predict_text(cmd, value, base);
    endtask

    task automatic test_extremes();
        send_number(1'b0, 16'h0000, 5'd10);
        send_number(1'b0, 16'h0000, 5'd2);
        send_number(1'b0, 16'hffff, 5'd2);
        send_number(1'b0, 16'hffff, 5'd16);
        send_number(1'b0, 16'hffff, 5'd10);
        send_number(1'b0, 16'h0001, 5'd2);
        send_number(1'b0, 16'h000f, 5'd16);
        send_number(1'b0, 16'h0010, 5'd16);
        send_number(1'b0, 16'd12345, 5'd7);
        send_number(1'b0, 16'h8000, 5'd10);
        send_number(1'b0, 16'hffff, 5'd3);
        send_number(1'b1, 16'h0000, 5'd3);
        send_number(1'b1, 16'h8000, 5'd2);
        send_number(1'b1, 16'h8000, 5'd10);
        send_number(1'b1, 16'hffff, 5'd10);
        send_number(1'b1, 16'h7fff, 5'd16);
        send_number(1'b1, 16'h7fff, 5'd10);
        send_number(1'b1, 16'h8001, 5'd16);
    endtask

    // radix values outside 2..16 are clamped
    task automatic test_radix_clamp();
        send_number(1'b0, 16'h00a5, 5'd0);
        send_number(1'b1, 16'hff5a, 5'd1);
        send_number(1'b0, 16'hbeef, 5'd17);
        send_number(1'b1, 16'h8000, 5'd31);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        logic [15:0] value;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: value = 16'($urandom);
                1: value = 16'($urandom_range(0, 20));
                2: begin
                    case ($urandom_range(3))
                        0: value = 16'h8000 + 16'($urandom_range(0, 4));
                        1: value = 16'h7fff - 16'($urandom_range(0, 4));
                        2: value = 16'hffff - 16'($urandom_range(0, 4));
                        default: value = 16'($urandom_range(0, 4));
                    endcase
                end
                default: value = 16'($urandom & ((32'd1 << $urandom_range(1, 16)) - 1));
            endcase
            send_number(1'($urandom_range(1)), value, 5'($urandom_range(2, 16)));
        end
    endtask

    always @(posedge i_clk) begin
        text_char_t exp_char;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character transfer: ascii_char %h last %b",
                       o_ascii_char, o_last);
                error_count++;
            end else begin
                exp_char = pending_chars.pop_front();
                if (o_ascii_char !== exp_char.code) begin
                    $error("ascii_char: expected %h, actual %h", exp_char.code, o_ascii_char);
                    error_count++;
                end
                if (o_last !== exp_char.last) begin
                    $error("last: expected %b, actual %b", exp_char.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = 1'b0;
        i_value = '0;
        i_base = 5'd10;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 31;
        test_extremes();
        test_radix_clamp();
        test_random(70, 31);
        test_random(70, 59);
        test_random(70, 0);

        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
